/* hdl/pfb_pkg.sv */
package pfb_pkg;

	// item kinds carried in s_tuser
	typedef enum logic [1:0] {
		CMD_PIXEL = 2'd0,
		CMD_BLIT  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic REG_PANEL_WIDTH  = 1'b0;
	localparam logic REG_PANEL_HEIGHT = 1'b1;

	localparam logic [7:0] PANEL_WIDTH_RST  = 8'd128;
	localparam logic [6:0] PANEL_HEIGHT_RST = 7'd64;

	// read-modify-write of one byte: new = (old & ~clr) | set
	typedef struct packed {
		logic       wr;
		logic [7:0] set;
		logic [7:0] clr;
	} bank_op_t;

	typedef struct packed {
		logic clip;
		logic rd_en;
		logic rd_bank;
	} item_ctl_t;

endpackage

/* hdl/pfb_decode.sv */
module pfb_decode import pfb_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int PAGES = 8,
	localparam int BANK_ROWS = (PAGES + 1) / 2,
	localparam int BANK_DEPTH = BANK_ROWS * COLUMNS,
	localparam int BAW = $clog2(BANK_DEPTH),
	localparam int RIW = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1,
	localparam int CW = $clog2(COLUMNS)
) (
	input  cmd_t                  cmd,
	input  logic [15:0]           column,
	input  logic [15:0]           row,
	input  logic [2:0]            page_offset,
	input  logic [7:0]            value,
	input  logic [7:0]            panel_width,
	input  logic [6:0]            panel_height,
	output item_ctl_t             ctl,
	output bank_op_t [1:0]        op,
	output logic [1:0][BAW-1:0]   addr
);

	logic        col_ok;
	logic        pix_clip;
	logic [2:0]  poff_eff;
	logic [13:0] pa;
	logic [13:0] pb;
	logic        lo_ok;
	logic        hi_ok;
	logic [7:0]  pix_mask;
	logic [15:0] blit_bits;
	logic [CW-1:0] col_idx;

	assign col_ok = !column[15] && (column < 16'(COLUMNS));
	assign col_idx = column[CW-1:0];

	assign pix_clip = !col_ok || (column >= {8'd0, panel_width}) || row[15] ||
		(row >= {9'd0, panel_height}) || (row >= 16'(8 * PAGES));

	// base page: floor(row/8), plus the image page offset for a blit
	assign poff_eff = (cmd == CMD_BLIT) ? page_offset : 3'd0;
	assign pa = {row[15], row[15:3]} + {11'd0, poff_eff};
	assign pb = pa + 14'd1;

	assign lo_ok = !pa[13] && (pa < 14'(PAGES));
	assign hi_ok = (row[2:0] != 3'd0) && !pb[13] && (pb < 14'(PAGES));

	assign pix_mask = 8'd1 << row[2:0];
	assign blit_bits = {8'd0, value} << row[2:0];

	always_comb begin
		ctl.clip = 1'b0;
		ctl.rd_en = 1'b0;
		ctl.rd_bank = pa[0];
		case (cmd)
			CMD_PIXEL: ctl.clip = pix_clip;
			CMD_BLIT:  ctl.clip = !col_ok || (!lo_ok && !hi_ok);
			CMD_READ: begin
				ctl.clip = !col_ok || !lo_ok;
				ctl.rd_en = col_ok && lo_ok;
			end
			default:   ctl.clip = 1'b0;
		endcase
	end

	// even pages live in bank 0, odd pages in bank 1; a blit's two pages
	// always land in different banks
	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic          is_lo;
		logic [13:0]   page_b;
		logic [RIW-1:0] row_idx;

		assign is_lo = (pa[0] == 1'(b));
		assign page_b = is_lo ? pa : pb;
		assign row_idx = page_b[RIW:1];
		assign addr[b] = BAW'(32'(row_idx) * COLUMNS + 32'(col_idx));

		always_comb begin
			op[b].wr = 1'b0;
			op[b].set = 8'd0;
			op[b].clr = 8'd0;
			case (cmd)
				CMD_PIXEL: begin
					op[b].wr = !pix_clip && is_lo;
					op[b].set = (value != 8'd0) ? pix_mask : 8'd0;
					op[b].clr = (value == 8'd0) ? pix_mask : 8'd0;
				end
				CMD_BLIT: begin
					op[b].wr = col_ok && (is_lo ? lo_ok : hi_ok);
					op[b].set = is_lo ? blit_bits[7:0] : blit_bits[15:8];
				end
				default: op[b].wr = 1'b0;
			endcase
		end
	end

endmodule

/* hdl/page_framebuffer_pixel_blit.sv */
// An accepted item passes stage 1, stage 2 and the result register before it shows on m_*.
// Throughput: one item per cycle unless stalled; the byte store is split into even and odd
// page banks, so a blit's two-page read-modify-write fits one bank port each.
// Reset: loads the panel registers with their reset values and runs a clearing
// pass over the store, one address of each bank per cycle across its (PAGES+1)/2*COLUMNS
// addresses (512 at defaults), with s_tready low; configuration writes are taken meanwhile.
module page_framebuffer_pixel_blit import pfb_pkg::*; #(
	parameter int COLUMNS = 128,
	parameter int PAGES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // column[15:0], row[31:16], page_offset[34:32], value[42:35]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // read_data[7:0]
	output logic [0:0]  m_tuser   // clipped[0]
);

	localparam int BANK_ROWS = (PAGES + 1) / 2;
	localparam int BANK_DEPTH = BANK_ROWS * COLUMNS;
	localparam int BAW = $clog2(BANK_DEPTH);

	// panel registers
	logic [7:0] panel_width_q;
	logic [6:0] panel_height_q;

	// clearing pass
	logic           clearing_q;
	logic [BAW-1:0] clr_cnt_q;

	// stage 1: accepted item
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] column_s1;
	logic [15:0] row_s1;
	logic [2:0]  poff_s1;
	logic [7:0]  value_s1;

	// stage 2: decoded item, bank read data arrives here
	logic                valid_s2;
	item_ctl_t           ctl_s2;
	bank_op_t [1:0]      op_s2;
	logic [1:0][BAW-1:0] addr_s2;

	// result register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_clip_q;

	item_ctl_t           dec_ctl;
	bank_op_t [1:0]      dec_op;
	logic [1:0][BAW-1:0] dec_addr;

	logic s1_adv;
	logic s2_adv;

	logic [1:0][7:0]     old_byte;
	logic [1:0][7:0]     new_byte;
	logic [1:0]          mem_we;
	logic [1:0][BAW-1:0] mem_wa;
	logic [1:0][7:0]     mem_wd;

	assign s2_adv = valid_s2 && (!out_valid_q || m_tready);
	assign s1_adv = valid_s1 && (!valid_s2 || s2_adv);
	assign s_tready = !clearing_q && (!valid_s1 || s1_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PANEL_WIDTH:  panel_width_q <= cfg_data;
				REG_PANEL_HEIGHT: panel_height_q <= cfg_data[6:0];
				default:          panel_width_q <= panel_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + BAW'(1);
			if (clr_cnt_q == BAW'(BANK_DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	// handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (s1_adv)
				valid_s1 <= 1'b0;
			if (s1_adv)
				valid_s2 <= 1'b1;
			else if (s2_adv)
				valid_s2 <= 1'b0;
			if (s2_adv)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_t'(s_tuser);
			column_s1 <= s_tdata[15:0];
			row_s1 <= s_tdata[31:16];
			poff_s1 <= s_tdata[34:32];
			value_s1 <= s_tdata[42:35];
		end
		if (s1_adv) begin
			ctl_s2 <= dec_ctl;
			op_s2 <= dec_op;
			addr_s2 <= dec_addr;
		end
		if (s2_adv) begin
			out_data_q <= ctl_s2.rd_en ? old_byte[ctl_s2.rd_bank] : 8'd0;
			out_clip_q <= ctl_s2.clip;
		end
	end

	pfb_decode #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) u_decode (
		.cmd(cmd_s1),
		.column(column_s1),
		.row(row_s1),
		.page_offset(poff_s1),
		.value(value_s1),
		.panel_width(panel_width_q),
		.panel_height(panel_height_q),
		.ctl(dec_ctl),
		.op(dec_op),
		.addr(dec_addr)
	);

	for (genvar b = 0; b < 2; b++) begin : g_bank
		logic [7:0] mem [BANK_DEPTH];
		logic [7:0] rd_q;
		logic       hit_q;
		logic [7:0] fwd_q;

		// clearing pass owns the write port until it ends
		assign mem_we[b] = clearing_q || (s2_adv && op_s2[b].wr);
		assign mem_wa[b] = clearing_q ? clr_cnt_q : addr_s2[b];
		assign mem_wd[b] = clearing_q ? 8'd0 : new_byte[b];

		always_ff @(posedge clk) begin
			if (mem_we[b])
				mem[mem_wa[b]] <= mem_wd[b];
			if (s1_adv)
				rd_q <= mem[dec_addr[b]];
		end

		// a write at the same edge as the read is missed by the read; keep
		// its byte and use it in stage 2 instead
		always_ff @(posedge clk) begin
			if (s1_adv) begin
				hit_q <= mem_we[b] && (mem_wa[b] == dec_addr[b]);
				fwd_q <= mem_wd[b];
			end
		end

		assign old_byte[b] = hit_q ? fwd_q : rd_q;
		assign new_byte[b] = (old_byte[b] & ~op_s2[b].clr) | op_s2[b].set;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_clip_q;

endmodule

/* bench/page_framebuffer_pixel_blit_test.sv */
`timescale 1ns / 100ps

// Bench for the page-organized 1bpp framebuffer.
// Items are queued by the sequencer (initial block below), offered by a
// clocked driver with random gaps, and predicted/checked by a clocked monitor
// that keeps its own copy of the frame store and the panel registers.
module page_framebuffer_pixel_blit_test;
	import pfb_pkg::*;

	localparam int FB_COLUMNS = 128;
	localparam int FB_PAGES   = 8;
	localparam int HALF_CYCLE = 4;
	// no-progress limit: covers the clear after reset, the long
	// receiver hold-off and the longest random gaps, several times over
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		cmd_t               cmd;
		logic signed [15:0] column;
		logic signed [15:0] row;
		logic [2:0]         page_off;
		logic [7:0]         value;
	} draw_item_t;

	typedef struct {
		logic [7:0] read_data;
		logic       clipped;
	} draw_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_PANEL_WIDTH;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = 48'd0;  // column[15:0], row[31:16], page_offset[34:32], value[42:35]
	logic [1:0]  s_tuser = CMD_NOP;  // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;  // read_data[7:0]
	logic [0:0]  m_tuser;  // clipped[0]

	page_framebuffer_pixel_blit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #HALF_CYCLE clk = ~clk;
	end

	// shadow of the block: frame bytes and panel registers
	logic [7:0] frame_copy [FB_COLUMNS*FB_PAGES];
	logic [7:0] shadow_width = PANEL_WIDTH_RST;
	logic [6:0] shadow_height = PANEL_HEIGHT_RST;

	draw_item_t   draw_queue[$];     // items waiting for the driver
	draw_result_t owed_results[$];   // predicted results not yet seen

	int items_queued = 0;
	int items_taken = 0;
	int error_count = 0;
	int stall_cycles = 0;
	int kind_count [4] = '{0, 0, 0, 0};
	int clip_count = 0;
	int lit_reads = 0;

	// pacing controls, written by the sequencer between phases
	bit idle_on = 1'b1;
	int hold_req = 0;

	// driver / receiver local state
	bit         in_took = 1'b0;
	int         send_gap = 0;
	int         stall_left = 0;
	int         hold_left = 0;
	int         hold_seen = 0;
	draw_item_t next_item;

	// gap lengths: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 2);
		end else if (r < 95) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(15, 40);
	endfunction

	function automatic bit page_in_range(int p);
		return p >= 0 && p < FB_PAGES;
	endfunction

	function automatic bit column_in_range(int c);
		return c >= 0 && c < FB_COLUMNS;
	endfunction

	// Apply one item to the shadow store and work out its result.
	task automatic draw_into_frame(input draw_item_t it, output draw_result_t res);
		int         c;
		int         r;
		int         page;
		int         bit_sel;
		int         idx;
		bit         upper_ok;
		bit         lower_ok;
		logic [15:0] spread;
		c = it.column;
		r = it.row;
		// keep the sum signed so the shift stays arithmetic
		page = (r >>> 3) + int'(it.page_off);
		bit_sel = r & 7;  // floored modulo, also for negative rows
		res.read_data = 8'd0;
		res.clipped = 1'b0;
		case (it.cmd)
			CMD_PIXEL: begin
				if (c < 0 || c >= int'(shadow_width) || c >= FB_COLUMNS ||
						r < 0 || r >= int'(shadow_height) || r >= 8*FB_PAGES) begin
					res.clipped = 1'b1;
				end else begin
					idx = (r >> 3)*FB_COLUMNS + c;
					if (it.value == 8'd0) begin
						frame_copy[idx][bit_sel] = 1'b0;
					end else begin
						frame_copy[idx][bit_sel] = 1'b1;
					end
				end
			end
			CMD_BLIT: begin
				// byte straddles two pages unless the origin is page aligned
				upper_ok = page_in_range(page);
				lower_ok = (bit_sel != 0) && page_in_range(page + 1);
				if (!column_in_range(c) || (!upper_ok && !lower_ok)) begin
					res.clipped = 1'b1;
				end else begin
					spread = {8'd0, it.value} << bit_sel;
					if (upper_ok) begin
						idx = page*FB_COLUMNS + c;
						frame_copy[idx] = frame_copy[idx] | spread[7:0];
					end
					if (lower_ok) begin
						idx = (page + 1)*FB_COLUMNS + c;
						frame_copy[idx] = frame_copy[idx] | spread[15:8];
					end
				end
			end
			CMD_READ: begin
				// page_offset plays no part in a read
				page = r >>> 3;
				if (!column_in_range(c) || !page_in_range(page)) begin
					res.clipped = 1'b1;
				end else begin
					res.read_data = frame_copy[page*FB_COLUMNS + c];
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic push_item(input cmd_t cmd, input int col, input int row,
			input int poff, input int val);
		draw_item_t it;
		it.cmd = cmd;
		it.column = 16'(col);
		it.row = 16'(row);
		it.page_off = 3'(poff);
		it.value = 8'(val);
		draw_queue.push_back(it);
		items_queued++;
	endtask

	// Random item, biased toward the visible panel and a few hot columns so
	// reads land on pixels that were drawn; a share covers the full 16 bits.
	task automatic push_random_item();
		int   r;
		int   col;
		int   row;
		int   poff;
		int   val;
		cmd_t cmd;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			cmd = CMD_PIXEL;
		end else if (r < 65) begin
			cmd = CMD_BLIT;
		end else if (r < 97) begin
			cmd = CMD_READ;
		end else begin
			cmd = CMD_NOP;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			col = $urandom_range(0, 15);
		end else if (r < 75) begin
			col = $urandom_range(0, 127);
		end else if (r < 88) begin
			col = $urandom_range(0, 135) - 4;
		end else begin
			col = $urandom_range(0, 65535);
		end
		r = $urandom_range(0, 99);
		if (r < 80) begin
			row = $urandom_range(0, 63);
		end else if (r < 90) begin
			row = $urandom_range(0, 87) - 12;
		end else begin
			row = $urandom_range(0, 65535);
		end
		poff = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(0, 7);
		val = $urandom_range(0, 255);
		if (cmd == CMD_PIXEL && $urandom_range(0, 9) < 3) begin
			val = 0;
		end
		push_item(cmd, col, row, poff, val);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// every queued item taken and every predicted result returned
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (items_taken != items_queued || owed_results.size() != 0);
	endtask

	// One random phase under one panel setting. The drain before the
	// register writes is also the sender's full pause.
	task automatic run_phase(input logic [7:0] width, input logic [7:0] height,
			input int count, input bit hold, input bit calm);
		wait_drained();
		repeat (3) @(negedge clk);
		write_reg(REG_PANEL_WIDTH, width);
		write_reg(REG_PANEL_HEIGHT, height);
		idle_on = !calm;
		repeat (count) push_random_item();
		// receiver stops for a long stretch while the driver keeps offering
		if (hold) begin
			hold_req++;
		end
		wait_drained();
	endtask

	// Driver: offers the next queued item once the current one is taken.
	always @(posedge clk) begin
		in_took <= s_tvalid && s_tready;
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_took)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (draw_queue.size() > 0) begin
				next_item = draw_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'd0, next_item.value, next_item.page_off,
					next_item.row, next_item.column};
				s_tuser <= next_item.cmd;
				if (idle_on && $urandom_range(0, 2) == 0) begin
					send_gap = pick_gap();
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure plus the requested long hold-off.
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!idle_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
		end
	end

	// Monitor: register writes and accepted items feed the shadow; each
	// returned item is checked against the oldest prediction.
	always @(posedge clk) begin : monitor
		draw_item_t   got_item;
		draw_result_t want;
		draw_result_t res;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_PANEL_WIDTH) begin
					shadow_width = cfg_data;
				end else begin
					shadow_height = cfg_data[6:0];
				end
			end
			if (s_tvalid && s_tready) begin
				got_item.cmd = cmd_t'(s_tuser);
				got_item.column = s_tdata[15:0];
				got_item.row = s_tdata[31:16];
				got_item.page_off = s_tdata[34:32];
				got_item.value = s_tdata[42:35];
				draw_into_frame(got_item, res);
				owed_results.push_back(res);
				items_taken++;
				kind_count[got_item.cmd]++;
				if (res.clipped) begin
					clip_count++;
				end
				if (res.read_data != 8'd0) begin
					lit_reads++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					flag_mismatch("result with nothing outstanding", m_tdata, 0);
				end else begin
					want = owed_results.pop_front();
					if (m_tdata !== want.read_data) begin
						flag_mismatch("read_data", m_tdata, want.read_data);
					end
					if (m_tuser[0] !== want.clipped) begin
						flag_mismatch("clipped", m_tuser[0], want.clipped);
					end
				end
			end
		end
	end

	// Watchdog: too long with no item moving on either side or the config port.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no progress for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Sequencer
	initial begin
		foreach (frame_copy[i]) frame_copy[i] = 8'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, at the reset panel size (registers left unwritten)
		push_item(CMD_PIXEL, 0, 0, 0, 8'h01);
		push_item(CMD_PIXEL, 127, 63, 0, 8'hFF);
		push_item(CMD_READ, 0, 0, 0, 0);
		push_item(CMD_READ, 127, 56, 0, 0);
		push_item(CMD_PIXEL, 0, 0, 0, 8'h00);        // clear
		push_item(CMD_READ, 0, 7, 0, 0);
		push_item(CMD_PIXEL, -1, 5, 0, 8'h01);       // left of panel
		push_item(CMD_PIXEL, 128, 5, 0, 8'h01);      // right edge is exclusive
		push_item(CMD_PIXEL, 5, -1, 0, 8'h01);
		push_item(CMD_PIXEL, 5, 64, 0, 8'h01);       // bottom edge is exclusive
		push_item(CMD_BLIT, 10, 5, 0, 8'hA5);        // straddles pages 0 and 1
		push_item(CMD_READ, 10, 0, 0, 0);
		push_item(CMD_READ, 10, 8, 0, 0);
		push_item(CMD_BLIT, 20, -3, 0, 8'hFF);       // upper page off top, lower kept
		push_item(CMD_BLIT, 30, 60, 0, 8'hFF);       // lower page off bottom
		push_item(CMD_BLIT, 40, 64, 0, 8'hFF);       // wholly below
		push_item(CMD_BLIT, 50, -8, 7, 8'h3C);       // negative origin, aligned
		push_item(CMD_BLIT, -1, 0, 0, 8'hFF);
		push_item(CMD_BLIT, 128, 0, 0, 8'hFF);
		push_item(CMD_BLIT, 127, -32768, 7, 8'hFF);
		push_item(CMD_BLIT, 0, 32767, 7, 8'hFF);
		push_item(CMD_READ, -32768, 0, 0, 0);
		push_item(CMD_READ, 32767, 32767, 7, 8'hFF);
		push_item(CMD_READ, 50, 55, 0, 0);
		push_item(CMD_READ, 20, -1, 0, 0);           // page above the store
		push_item(CMD_NOP, -1, -1, 7, 8'hFF);

		// random phases; extremes of both registers, including values the
		// panel range does not name (zero width, height data above 7 bits)
		run_phase(8'd128, 8'd64, 240, 1'b0, 1'b1);
		run_phase(8'd1, 8'd8, 240, 1'b1, 1'b0);
		run_phase(8'd255, 8'd200, 240, 1'b0, 1'b0);
		run_phase(8'd0, 8'd0, 200, 1'b0, 1'b0);
		run_phase(8'd77, 8'd45, 240, 1'b1, 1'b0);
		run_phase(8'd128, 8'd64, 250, 1'b0, 1'b0);

		// allow a margin for stray results
		repeat (10) @(negedge clk);
		$display("Covered %0d items: %0d pixel, %0d blit, %0d read, %0d unused kind",
			items_taken, kind_count[CMD_PIXEL], kind_count[CMD_BLIT],
			kind_count[CMD_READ], kind_count[CMD_NOP]);
		$display("%0d accesses clipped, %0d reads returned lit pixels, %0d mismatches",
			clip_count, lit_reads, error_count);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/pfb_pkg.sv
hdl/pfb_decode.sv
hdl/page_framebuffer_pixel_blit.sv
bench/page_framebuffer_pixel_blit_test.sv
